// ===== hdl/ifht_pkg.sv =====
package ifht_pkg;

    localparam int MAX_HOLES    = 16;
    localparam int IDX_W        = $clog2(MAX_HOLES);
    localparam int CNT_W        = $clog2(MAX_HOLES + 1);
    localparam int PIECE_W      = $clog2(2 * MAX_HOLES + 1);
    localparam int POS_W        = 17;
    localparam int HOLE_END_MAX = 65536;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic {
        CMD_INIT     = 1'b0,
        CMD_FRAGMENT = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic              over;
        logic [15:0]       first;
        logic [POS_W-1:0]  last;
        logic              more;
    } t_job;

    typedef struct packed {
        logic [15:0]       datagram_length;
        logic [4:0]        hole_count;
        logic              complete;
        logic              table_full;
        logic              accepted;
    } t_result;

endpackage

// ===== hdl/ifht_front.sv =====
module ifht_front
    import ifht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [15:0] i_frag_offset,
    input  logic [15:0] i_frag_length,
    input  logic        i_more_fragments,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_queue_full
);

    logic [15:0]      r_capacity;
    logic [POS_W-1:0] w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_queue_full;
    assign o_push      = i_valid && !i_queue_full;
    assign w_last      = {1'b0, i_frag_offset} + {1'b0, i_frag_length};

    always_comb begin
        o_job.cmd   = t_cmd'(i_command);
        o_job.over  = w_last > {1'b0, r_capacity};
        o_job.first = i_frag_offset;
        o_job.last  = w_last;
        o_job.more  = i_more_fragments;
    end

endmodule

// ===== hdl/ifht_queue.sv =====
module ifht_queue
    import ifht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH)-1:0] r_wr_ptr;
    logic [$clog2(QUEUE_DEPTH)-1:0] r_rd_ptr;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = r_count == QUEUE_DEPTH[$clog2(QUEUE_DEPTH+1)-1:0];
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];

endmodule

// ===== hdl/ifht_back.sv =====
module ifht_back
    import ifht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state           r_state;
    t_job             r_job;
    logic             r_bank;
    logic             r_fresh;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_total;
    logic [IDX_W-1:0] r_idx;
    logic [PIECE_W-1:0] r_n;
    logic             r_out_valid;
    t_result          r_out;
    logic [POS_W-1:0] r_beg [2][MAX_HOLES];
    logic [POS_W-1:0] r_end [2][MAX_HOLES];
    logic [POS_W-1:0] r_rd_beg;
    logic [POS_W-1:0] r_rd_end;

    logic               w_slot_free;
    logic [IDX_W-1:0]   w_rd_idx;
    logic [POS_W-1:0]   w_hb;
    logic [POS_W-1:0]   w_he;
    logic               w_skip;
    logic               w_head;
    logic               w_tail;
    logic               w_wr0;
    logic               w_wr1;
    logic [POS_W-1:0]   w_b0;
    logic [POS_W-1:0]   w_e0;
    logic [POS_W-1:0]   w_b1;
    logic [POS_W-1:0]   w_e1;
    logic [PIECE_W-1:0] w_n1;
    logic               w_last_idx;
    logic               w_full;

    assign w_slot_free = !r_out_valid || i_ready;
    assign w_rd_idx = (r_state == S_WALK) ? r_idx + 1'b1 : '0;
    assign w_hb = r_fresh ? '0 : r_rd_beg;
    assign w_he = r_fresh ? POS_W'(HOLE_END_MAX) : r_rd_end;
    assign w_skip = ({1'b0, r_job.first} > w_he) || (r_job.last < w_hb);
    assign w_head = !w_skip && ({1'b0, r_job.first} > w_hb);
    assign w_tail = !w_skip && (r_job.last < w_he) && r_job.more;
    assign w_n1   = r_n + 1'b1;
    assign w_last_idx = {1'b0, r_idx} == (r_cnt - 1'b1);
    assign w_full = r_n > PIECE_W'(MAX_HOLES);

    always_comb begin
        w_wr0 = w_skip || w_head || w_tail;
        w_wr1 = w_head && w_tail;
        w_b0  = w_hb;
        w_e0  = w_he;
        w_b1  = r_job.last;
        w_e1  = w_he;
        if (w_skip) begin
            w_b0 = w_hb;
            w_e0 = w_he;
        end else if (w_head) begin
            w_e0 = {1'b0, r_job.first};
        end else begin
            w_b0 = r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_beg <= r_beg[r_bank][w_rd_idx];
        r_rd_end <= r_end[r_bank][w_rd_idx];
        if (r_state == S_WALK) begin
            if (w_wr0 && r_n < PIECE_W'(MAX_HOLES)) begin
                r_beg[!r_bank][r_n[IDX_W-1:0]] <= w_b0;
                r_end[!r_bank][r_n[IDX_W-1:0]] <= w_e0;
            end
            if (w_wr1 && w_n1 < PIECE_W'(MAX_HOLES)) begin
                r_beg[!r_bank][w_n1[IDX_W-1:0]] <= w_b1;
                r_end[!r_bank][w_n1[IDX_W-1:0]] <= w_e1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_fresh     <= 1'b1;
            r_cnt       <= CNT_W'(1);
            r_total     <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_job.cmd == CMD_INIT) begin
                            if (w_slot_free) begin
                                r_fresh                <= 1'b1;
                                r_cnt                  <= CNT_W'(1);
                                r_total                <= '0;
                                r_out_valid            <= 1'b1;
                                r_out.accepted         <= 1'b1;
                                r_out.table_full       <= 1'b0;
                                r_out.complete         <= 1'b0;
                                r_out.hole_count       <= 5'(1);
                                r_out.datagram_length  <= '0;
                            end
                        end else if (i_job.over) begin
                            if (w_slot_free) begin
                                r_out_valid            <= 1'b1;
                                r_out.accepted         <= 1'b0;
                                r_out.table_full       <= 1'b0;
                                r_out.complete         <= r_cnt == '0;
                                r_out.hole_count       <= 5'(r_cnt);
                                r_out.datagram_length  <= r_total;
                            end
                        end else begin
                            r_job   <= i_job;
                            r_idx   <= '0;
                            r_n     <= '0;
                            r_state <= (r_cnt == '0) ? S_DONE : S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    r_n   <= r_n + PIECE_W'(w_wr0) + PIECE_W'(w_wr1);
                    r_idx <= r_idx + 1'b1;
                    if (w_last_idx) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (w_full) begin
                            r_out.accepted         <= 1'b0;
                            r_out.table_full       <= 1'b1;
                            r_out.complete         <= r_cnt == '0;
                            r_out.hole_count       <= 5'(r_cnt);
                            r_out.datagram_length  <= r_total;
                        end else begin
                            r_bank                 <= !r_bank;
                            r_fresh                <= 1'b0;
                            r_cnt                  <= r_n[CNT_W-1:0];
                            r_out.accepted         <= 1'b1;
                            r_out.table_full       <= 1'b0;
                            r_out.complete         <= r_n == '0;
                            r_out.hole_count       <= 5'(r_n);
                            if (!r_job.more) begin
                                r_total               <= r_job.last[15:0];
                                r_out.datagram_length <= r_job.last[15:0];
                            end else begin
                                r_out.datagram_length <= r_total;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_pop    = (r_state == S_IDLE) && i_valid &&
                      (w_slot_free || (i_job.cmd == CMD_FRAGMENT && !i_job.over));
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/ip_fragment_hole_tracker_core.sv =====
// Path: an init or an over-capacity fragment passes the queue and then the output register;
// a walked fragment passes the queue, the states S_IDLE, S_WALK and S_DONE, then the output register.
// Throughput: one item per cycle for inits and over-capacity fragments while the output is not
// stalled; a walked fragment holds the back end while it walks one hole entry per cycle.
// Reset is synchronous: the table holds the single full hole, length and capacity
// take their reset values, and the queue and output stage are emptied.
module ip_fragment_hole_tracker_core
    import ifht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // frag_offset [15:0], frag_length [31:16], more_fragments [32], zero fill [39:33]
    input  logic [39:0] i_s_axis_tdata,
    // command [0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // accepted [0], table_full [1], complete [2], hole_count [7:3], datagram_length [23:8]
    output logic [23:0] o_m_axis_tdata
);

    logic    w_push;
    t_job    w_push_job;
    logic    w_queue_full;
    logic    w_pop;
    logic    w_queue_valid;
    t_job    w_queue_job;
    t_result w_result;

    ifht_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_command       (i_s_axis_tuser),
        .i_frag_offset   (i_s_axis_tdata[15:0]),
        .i_frag_length   (i_s_axis_tdata[31:16]),
        .i_more_fragments(i_s_axis_tdata[32]),
        .o_push          (w_push),
        .o_job           (w_push_job),
        .i_queue_full    (w_queue_full)
    );

    ifht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_job   (w_queue_job)
    );

    ifht_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_queue_valid),
        .i_job    (w_queue_job),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    assign o_m_axis_tdata = w_result;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ifht_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_cmd        cmd;
        logic [15:0] offset;
        logic [15:0] length;
        logic        more;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [39:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;

    logic [POS_W-1:0] hole_lo [MAX_HOLES];
    logic [POS_W-1:0] hole_hi [MAX_HOLES];
    bit               hole_on [MAX_HOLES];
    logic [15:0]      known_length;
    logic [15:0]      capacity;

    t_result pending_results[$];
    int      mismatches = 0;
    int      cycles = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      hold_requests = 0;
    int      holds_seen = 0;
    int      hold_left = 0;
    t_row    rows[$];

    ip_fragment_hole_tracker_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic void append_row(t_row row);
        rows.insert(rows.size(), row);
    endfunction

    function automatic void append_expected(t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void clear_holes();
        for (int i = 0; i < MAX_HOLES; i++) begin
            hole_lo[i] = '0;
            hole_hi[i] = '0;
            hole_on[i] = 0;
        end
        hole_hi[0] = POS_W'(HOLE_END_MAX);
        hole_on[0] = 1;
        known_length = '0;
    endfunction

    function automatic t_result track_fragment(t_cmd cmd, logic [15:0] offset,
                                               logic [15:0] length, logic more);
        logic [POS_W-1:0] lo [2*MAX_HOLES];
        logic [POS_W-1:0] hi [2*MAX_HOLES];
        logic [POS_W-1:0] stop;
        int      n;
        int      holes;
        t_result r;
        r = '0;
        n = 0;
        holes = 0;
        stop = {1'b0, offset} + {1'b0, length};
        if (cmd == CMD_INIT) begin
            clear_holes();
            r.accepted = 1'b1;
        end else if (stop <= {1'b0, capacity}) begin
            for (int i = 0; i < MAX_HOLES; i++) begin
                if (hole_on[i]) begin
                    if ({1'b0, offset} > hole_hi[i] || stop < hole_lo[i]) begin
                        lo[n] = hole_lo[i];
                        hi[n] = hole_hi[i];
                        n++;
                    end else begin
                        if ({1'b0, offset} > hole_lo[i]) begin
                            lo[n] = hole_lo[i];
                            hi[n] = {1'b0, offset};
                            n++;
                        end
                        if (stop < hole_hi[i] && more) begin
                            lo[n] = stop;
                            hi[n] = hole_hi[i];
                            n++;
                        end
                    end
                end
            end
            if (n > MAX_HOLES) begin
                r.table_full = 1'b1;
            end else begin
                for (int i = 0; i < MAX_HOLES; i++) begin
                    hole_on[i] = (i < n);
                    hole_lo[i] = (i < n) ? lo[i] : '0;
                    hole_hi[i] = (i < n) ? hi[i] : '0;
                end
                if (!more) begin
                    known_length = stop[15:0];
                end
                r.accepted = 1'b1;
            end
        end
        for (int i = 0; i < MAX_HOLES; i++) begin
            if (hole_on[i]) begin
                holes++;
            end
        end
        r.hole_count = holes[4:0];
        r.complete = (holes == 0);
        r.datagram_length = known_length;
        return r;
    endfunction

    task automatic send_fragment(t_cmd cmd, logic [15:0] offset, logic [15:0] length,
                                 logic more, bit typed, t_result want);
        t_result r;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= cmd;
        i_s_axis_tdata <= {7'b0, more, length, offset};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        r = track_fragment(cmd, offset, length, more);
        append_expected(typed ? want : r);
        if ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            while ($urandom_range(99) < idle_pct) begin
                @(posedge i_clk);
            end
            @(posedge i_clk);
        end
    endtask

    task automatic write_capacity(logic [15:0] value);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending_results.size() == 0);
        repeat (25) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        capacity = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_fragment();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_fragment(CMD_INIT, 16'($urandom), 16'($urandom), 1'($urandom), 0, '0);
        end else if (pick < 80) begin
            send_fragment(CMD_FRAGMENT, 16'($urandom_range(250) * 8),
                          16'($urandom_range(600)), ($urandom_range(99) < 80), 0, '0);
        end else begin
            send_fragment(CMD_FRAGMENT, 16'($urandom), 16'($urandom), 1'($urandom), 0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ip_fragment_hole_tracker_core regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer %h", $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.accepted !== want.accepted) begin
                    $display("%0t: accepted expected %0d got %0d", $time,
                             want.accepted, got.accepted);
                    mismatches++;
                end
                if (got.table_full !== want.table_full) begin
                    $display("%0t: table_full expected %0d got %0d", $time,
                             want.table_full, got.table_full);
                    mismatches++;
                end
                if (got.complete !== want.complete) begin
                    $display("%0t: complete expected %0d got %0d", $time,
                             want.complete, got.complete);
                    mismatches++;
                end
                if (got.hole_count !== want.hole_count) begin
                    $display("%0t: hole_count expected %0d got %0d", $time,
                             want.hole_count, got.hole_count);
                    mismatches++;
                end
                if (got.datagram_length !== want.datagram_length) begin
                    $display("%0t: datagram_length expected %0d got %0d", $time,
                             want.datagram_length, got.datagram_length);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int idle_set [4];
        int stall_set [4];
        logic [15:0] cap_set [4];
        idle_set = '{0, 62, 0, 25};
        stall_set = '{0, 0, 62, 25};
        cap_set = '{16'hFFFF, 16'd0, 16'($urandom_range(800, 2000)), 16'hFFFF};
        clear_holes();
        capacity = 16'hFFFF;

        append_row('{CMD_INIT, 16'd0, 16'd0, 1'b0, 1, '{16'd0, 5'd1, 1'b0, 1'b0, 1'b1}});
        append_row('{CMD_FRAGMENT, 16'd0, 16'hFFFF, 1'b0, 1,
                     '{16'hFFFF, 5'd0, 1'b1, 1'b0, 1'b1}});
        append_row('{CMD_FRAGMENT, 16'hFFFF, 16'hFFFF, 1'b1, 1,
                     '{16'hFFFF, 5'd0, 1'b1, 1'b0, 1'b0}});
        append_row('{CMD_INIT, 16'hFFFF, 16'hFFFF, 1'b1, 1,
                     '{16'd0, 5'd1, 1'b0, 1'b0, 1'b1}});
        append_row('{CMD_FRAGMENT, 16'd100, 16'd50, 1'b1, 0, '0});
        append_row('{CMD_FRAGMENT, 16'd150, 16'd0, 1'b1, 0, '0});
        append_row('{CMD_FRAGMENT, 16'd0, 16'd0, 1'b0, 0, '0});
        append_row('{CMD_INIT, 16'd0, 16'd0, 1'b0, 1, '{16'd0, 5'd1, 1'b0, 1'b0, 1'b1}});
        for (int k = 1; k <= 16; k++) begin
            append_row('{CMD_FRAGMENT, 16'(4 * k + 2), 16'd1, 1'b1, (k == 16),
                         '{16'd0, 5'd16, 1'b0, 1'b1, 1'b0}});
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_fragment(rows[i].cmd, rows[i].offset, rows[i].length, rows[i].more,
                          rows[i].typed, rows[i].want);
        end

        for (int p = 0; p < 4; p++) begin
            write_capacity(cap_set[p]);
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            if (p == 0) begin
                hold_requests++;
            end
            for (int n = 0; n < 180; n++) begin
                if (n == 90) begin
                    i_s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    wait (pending_results.size() == 0);
                    @(posedge i_clk);
                end
                random_fragment();
            end
        end
        i_s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ip_fragment_hole_tracker_core regression: pass");
        end else begin
            $display("ip_fragment_hole_tracker_core regression: fail");
        end
        $finish;
    end

endmodule
